### design/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [0:0] {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } req_t;

endpackage

### design/lkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lkv_front.sv
// Front end: accepts request items, decodes the kind and queues them.
`timescale 1ns / 1ps

module lkv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_put_i,
  input  logic [lkv_pkg::KEY_W-1:0]     in_key_i,
  input  logic [lkv_pkg::VAL_W-1:0]     in_value_i,
  output logic                          req_valid_o,
  input  logic                          req_ready_i,
  output lkv_pkg::req_t                 req_o
);

  lkv_pkg::req_t                  slot_q [lkv_pkg::QUEUE_DEPTH];
  logic [lkv_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [lkv_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [lkv_pkg::QCNT_W-1:0]     count_q, count_d;
  lkv_pkg::req_t                  in_req;
  logic                           push, pop;

  always_comb begin
    in_req.op    = in_put_i ? lkv_pkg::OP_PUT : lkv_pkg::OP_GET;
    in_req.key   = in_key_i;
    in_req.value = in_value_i;
  end

  assign in_ready_o  = (count_q != lkv_pkg::QCNT_W'(lkv_pkg::QUEUE_DEPTH));
  assign req_valid_o = (count_q != '0);
  assign req_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + lkv_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + lkv_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + lkv_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - lkv_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_req;
    end
  end

endmodule

### design/lkv_back.sv
// Back end: key compare, age-rank update, value RAM and result register.
`timescale 1ns / 1ps

module lkv_back #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lkv_pkg::CAP_W-1:0]     cap_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  lkv_pkg::req_t                 req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_hit_o,
  output logic [lkv_pkg::VAL_W-1:0]     out_read_value_o,
  output logic                          out_evicted_o,
  output logic [lkv_pkg::KEY_W-1:0]     out_evicted_key_o
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW = IW;
  localparam int OW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (OW > lkv_pkg::CAP_W) ? OW : lkv_pkg::CAP_W;

  logic [lkv_pkg::KEY_W-1:0] key_q  [MAX_ENTRIES];
  logic [RW-1:0]             rank_q [MAX_ENTRIES];
  logic [RW-1:0]             rank_d [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    valid_q, valid_d;
  logic [OW-1:0]             occ_q, occ_d;

  logic [MAX_ENTRIES-1:0]    match_vec;
  logic                      hit;
  logic [IW-1:0]             match_idx, free_idx, victim_idx, slot_idx;
  logic [CW-1:0]             cap_x, eff_cap;
  logic                      full;
  logic                      fire, is_put, put_miss, do_promote, promote_all;
  logic [RW-1:0]             limit;

  // Result stage (waits for the RAM read) and output register.
  logic                      r_valid_q, r_hit_q, r_get_hit_q, r_ev_q;
  logic [lkv_pkg::KEY_W-1:0] r_evkey_q;
  logic                      r_adv;
  logic                      o_valid_q, o_hit_q, o_ev_q;
  logic [lkv_pkg::VAL_W-1:0] o_rval_q;
  logic [lkv_pkg::KEY_W-1:0] o_evkey_q;
  logic [lkv_pkg::VAL_W-1:0] ram_rdata;
  logic                      ram_we, ram_re;

  assign r_adv       = !o_valid_q || out_ready_i;
  assign req_ready_o = !r_valid_q || r_adv;
  assign fire        = req_valid_i && req_ready_o;
  assign is_put      = (req_i.op == lkv_pkg::OP_PUT);

  // Parallel key compare and slot selection.
  always_comb begin
    match_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      match_vec[i] = valid_q[i] && (key_q[i] == req_i.key);
      if (match_vec[i]) begin
        match_idx = IW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IW'(i);
      end
      // Ranks of valid entries are distinct; the oldest sits at occupancy - 1.
      if (valid_q[i] && (OW'(rank_q[i]) == occ_q - OW'(1))) begin
        victim_idx = IW'(i);
      end
    end
    hit = |match_vec;
  end

  always_comb begin
    cap_x = CW'(cap_i);
    if (cap_x == '0) begin
      eff_cap = CW'(1);
    end else if (cap_x > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_x;
    end
    full = (CW'(occ_q) >= eff_cap);
  end

  assign put_miss    = fire && is_put && !hit;
  assign slot_idx    = hit ? match_idx : (full ? victim_idx : free_idx);
  assign do_promote  = fire && (hit || is_put);
  assign promote_all = !hit;
  assign limit       = rank_q[match_idx];

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (do_promote) begin
        if (IW'(i) == slot_idx) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (promote_all || (rank_q[i] < limit))) begin
          rank_d[i] = rank_q[i] + RW'(1);
        end
      end
    end
    if (put_miss) begin
      valid_d[slot_idx] = 1'b1;
      // A full insert evicts one and adds one: occupancy holds.
      if (!full) begin
        occ_d = occ_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (put_miss) begin
      key_q[slot_idx] <= req_i.key;
    end
  end

  assign ram_we = fire && is_put;
  assign ram_re = fire && !is_put && hit;

  lkv_ram #(
    .WIDTH (lkv_pkg::VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_idx),
    .wdata_i (req_i.value),
    .re_i    (ram_re),
    .raddr_i (match_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      // Load on a new item, drain when the output register takes it, else hold.
      if (fire) begin
        r_valid_q <= 1'b1;
      end else if (r_adv) begin
        r_valid_q <= 1'b0;
      end
      if (r_valid_q && r_adv) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_hit_q     <= hit;
      r_get_hit_q <= ram_re;
      r_ev_q      <= put_miss && full;
      r_evkey_q   <= (put_miss && full) ? key_q[victim_idx] : '0;
    end
    if (r_valid_q && r_adv) begin
      o_hit_q   <= r_hit_q;
      o_rval_q  <= r_get_hit_q ? ram_rdata : '0;
      o_ev_q    <= r_ev_q;
      o_evkey_q <= r_evkey_q;
    end
  end

  assign out_valid_o       = o_valid_q;
  assign out_hit_o         = o_hit_q;
  assign out_read_value_o  = o_rval_q;
  assign out_evicted_o     = o_ev_q;
  assign out_evicted_key_o = o_evkey_q;

endmodule

### design/lru_key_value_cache.sv
// Top level: LRU key-value cache with stream ports and a capacity register.
// Path: an accepted item passes the request queue, the compare-and-update
//   stage with the value RAM read, and the output register before its result is offered.
// Throughput: one item per cycle while the output is not stalled; the key compare and
//   age-rank update in the back end are combinational.
// Reset empties the cache at once (valid bits in flops, no clearing pass)
//   and sets the capacity register to 16.
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,        // capacity_in_use
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [0:0]  s_axis_tuser_i,     // [0] req_type
  input  logic [63:0] s_axis_tdata_i,     // [31:0] key, [63:32] write_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [1:0]  m_axis_tuser_o,     // [0] hit, [1] evicted
  output logic [63:0] m_axis_tdata_o      // [31:0] read_value, [63:32] evicted_key
);

  logic [lkv_pkg::CAP_W-1:0] cap_q;
  logic                      req_valid, req_ready;
  lkv_pkg::req_t             req;
  logic                      out_hit, out_ev;
  logic [lkv_pkg::VAL_W-1:0] out_rval;
  logic [lkv_pkg::KEY_W-1:0] out_evkey;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lkv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_put_i    (s_axis_tuser_i[0]),
    .in_key_i    (s_axis_tdata_i[31:0]),
    .in_value_i  (s_axis_tdata_i[63:32]),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  lkv_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cap_i             (cap_q),
    .req_valid_i       (req_valid),
    .req_ready_o       (req_ready),
    .req_i             (req),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_hit_o         (out_hit),
    .out_read_value_o  (out_rval),
    .out_evicted_o     (out_ev),
    .out_evicted_key_o (out_evkey)
  );

  assign m_axis_tuser_o = {out_ev, out_hit};
  assign m_axis_tdata_o = {out_evkey, out_rval};

endmodule
